// ===== rtl/core/gda_pkg.sv =====
// types, constants and calendar functions shared by the date-add block
// no dependencies

package gda_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned ADD_W   = 14;
    localparam int unsigned IYEAR_W = 15;
    localparam int unsigned REM_W   = 15;
    localparam int unsigned Y400_W  = 9;
    localparam int unsigned YLEN_W  = 9;
    localparam int unsigned SHIFT_W = 3;

    localparam logic [SHIFT_W-1:0] MOD_TOP_SHIFT = 3'd5;
    localparam logic [REM_W-1:0]   CYCLE_400     = 15'd400;
    localparam logic [Y400_W-1:0]  Y400_LAST     = 9'd399;
    localparam logic [Y400_W-1:0]  Y400_100      = 9'd100;
    localparam logic [Y400_W-1:0]  Y400_200      = 9'd200;
    localparam logic [Y400_W-1:0]  Y400_300      = 9'd300;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MOD   = 5'b00010,
        S_DOY   = 5'b00100,
        S_YEAR  = 5'b01000,
        S_MONTH = 5'b10000
    } t_state;

    typedef struct packed {
        logic               load;
        logic               mod_step;
        logic [SHIFT_W-1:0] mod_shift;
        logic               doy;
        logic               year_step;
        logic               month_step;
        logic               out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } t_dp_sts;

    // month length, zero outside january..december
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m, months past december add nothing
    function automatic logic [YLEN_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [YLEN_W-1:0] base;
        unique case (m)
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            4'd12:      base = 9'd334;
            default:    base = 9'd365;
        endcase
        return base + YLEN_W'(leap && (m > MONTH_FEB));
    endfunction

endpackage

// ===== rtl/core/gda_in_if.sv =====
// request channel carrying the start date and day count
// depends on gda_pkg

interface gda_in_if import gda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADD_W-1:0]   days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input ready);
    modport sink (input valid, start_year, start_month, start_day, days_to_add,
                  output ready);
endinterface

// ===== rtl/core/gda_out_if.sv =====
// result channel carrying the end date
// depends on gda_pkg

interface gda_out_if import gda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;

    modport source (output valid, end_year, end_month, end_day, input ready);
    modport sink (input valid, end_year, end_month, end_day, output ready);
endinterface

// ===== rtl/core/gda_datapath.sv =====
// date-add datapath: year mod 400 unit, day-of-year adder, year/month walk
// and result register; depends on gda_pkg

module gda_datapath import gda_pkg::*; (
    input  logic               i_clk,
    input  logic [YEAR_W-1:0]  i_start_year,
    input  logic [MONTH_W-1:0] i_start_month,
    input  logic [DAY_W-1:0]   i_start_day,
    input  logic [ADD_W-1:0]   i_days_to_add,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic [YEAR_W-1:0]  o_end_year,
    output logic [MONTH_W-1:0] o_end_month,
    output logic [DAY_W-1:0]   o_end_day
);

    logic [IYEAR_W-1:0] r_year, n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [REM_W-1:0]   r_mod, n_mod;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [MONTH_W-1:0] r_m, n_m;
    logic [YEAR_W-1:0]  r_end_year;
    logic [MONTH_W-1:0] r_end_month;
    logic [DAY_W-1:0]   r_end_day;

    logic [Y400_W-1:0]  y400;
    logic               leap;
    logic [YLEN_W-1:0]  year_len;
    logic [DAY_W-1:0]   cur_len;
    logic [REM_W-1:0]   mod_sub;
    logic [Y400_W-1:0]  y400_inc;

    assign y400     = r_mod[Y400_W-1:0];
    assign leap     = (r_year[1:0] == 2'b00) && (y400 != Y400_100) &&
                      (y400 != Y400_200) && (y400 != Y400_300);
    assign year_len = 9'd365 + YLEN_W'(leap);
    assign cur_len  = month_len(r_m, leap);
    assign mod_sub  = CYCLE_400 << i_cmd.mod_shift;
    assign y400_inc = (y400 == Y400_LAST) ? '0 : y400 + 9'd1;

    assign o_sts.year_fits  = r_rem <= REM_W'(year_len);
    assign o_sts.month_fits = REM_W'(cur_len) >= r_rem;

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_mod   = r_mod;
        n_rem   = r_rem;
        n_m     = r_m;
        priority if (i_cmd.load) begin
            n_year  = {1'b0, i_start_year};
            n_month = i_start_month;
            n_mod   = {1'b0, i_start_year};
            n_rem   = REM_W'(i_start_day) + REM_W'(i_days_to_add);
            n_m     = MONTH_JAN;
        end else if (i_cmd.mod_step) begin
            if (r_mod >= mod_sub) begin
                n_mod = r_mod - mod_sub;
            end
        end else if (i_cmd.doy) begin
            n_rem = r_rem + REM_W'(days_before(r_month, leap));
        end else if (i_cmd.year_step) begin
            n_rem  = r_rem - REM_W'(year_len);
            n_year = r_year + 15'd1;
            n_mod  = REM_W'(y400_inc);
        end else if (i_cmd.month_step) begin
            n_rem = r_rem - REM_W'(cur_len);
            if (r_m == MONTH_DEC) begin
                n_m    = MONTH_JAN;
                n_year = r_year + 15'd1;
                n_mod  = REM_W'(y400_inc);
            end else begin
                n_m = r_m + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_mod   <= n_mod;
        r_rem   <= n_rem;
        r_m     <= n_m;
        if (i_cmd.out_load) begin
            r_end_year  <= r_year[YEAR_W-1:0];
            r_end_month <= r_m;
            r_end_day   <= r_rem[DAY_W-1:0];
        end
    end

    assign o_end_year  = r_end_year;
    assign o_end_month = r_end_month;
    assign o_end_day   = r_end_day;

endmodule

// ===== rtl/core/gda_ctrl.sv =====
// date-add controller: sequences load, mod 400 steps, day of year, walk
// and result hand-off; depends on gda_pkg

module gda_ctrl import gda_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [SHIFT_W-1:0] r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mod_shift = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = MOD_TOP_SHIFT;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DOY;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_DOY: begin
                o_cmd.doy = 1'b1;
                n_state   = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.year_fits) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (!i_sts.month_fits) begin
                    o_cmd.month_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/gregorian_date_add_days.sv =====
// Gregorian date advance: one request (start date, days to add) gives one end
// date. From acceptance to result it loads, reduces the year mod 400 in six
// steps, forms the day of the year, steps whole years (at most 45) until the
// year fits, steps months (at most 11) through the final year, and loads the
// result register, which waits for as long as the previous result is still
// held there. A new request is taken as soon as the previous result is in the
// output register, even while that result waits to be taken. Month 0 and
// months above 12 are accepted and handled as the plain month table extended
// with zero-day months.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_ctrl and gda_datapath.

module gregorian_date_add_days import gda_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gda_in_if.sink  i_req,
    gda_out_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    gda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gda_datapath u_dp (
        .i_clk         (i_clk),
        .i_start_year  (i_req.start_year),
        .i_start_month (i_req.start_month),
        .i_start_day   (i_req.start_day),
        .i_days_to_add (i_req.days_to_add),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_end_year    (o_res.end_year),
        .o_end_month   (o_res.end_month),
        .o_end_day     (o_res.end_day)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mod_step, cmd.doy, cmd.year_step, cmd.month_step,
                  cmd.out_load}))
        else $error("datapath commands overlap");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while busy");

    a_result_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_res.valid)
        else $error("result register loaded without valid");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.end_month >= MONTH_JAN && o_res.end_month <= MONTH_DEC))
        else $error("end month out of range");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for gregorian_date_add_days: date requests in, end dates out
// depends on gda_pkg, gda_in_if, gda_out_if and the gregorian_date_add_days rtl

module tb;
    import gda_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 80;
    localparam int unsigned NUM_ANY     = 480;
    localparam int unsigned NUM_VALID   = 500;
    localparam int unsigned NUM_LEAP    = 500;
    localparam int unsigned NUM_STALL   = 60;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_end_date;

    logic i_clk;
    logic i_rst_n;
    logic holding;

    int unsigned tx_gap_max;
    int unsigned rx_gap_max;
    int unsigned cycle_count;
    int unsigned bad_results;
    int unsigned results_seen;
    int unsigned requests_sent;

    t_end_date pending_dates[$];

    gda_in_if  req_if ();
    gda_out_if res_if ();

    gregorian_date_add_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned m);
        int unsigned len;
        case (m)
            2: begin
                if ((yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0)))
                    len = 29;
                else
                    len = 28;
            end
            4, 6, 9, 11: len = 30;
            1, 3, 5, 7, 8, 10, 12: len = 31;
            default: len = 0;
        endcase
        return len;
    endfunction

    // day of year from the start date, then walk months forward from january
    function automatic t_end_date advance_date(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] mo,
                                               input logic [DAY_W-1:0] d,
                                               input logic [ADD_W-1:0] n);
        int unsigned yr;
        int unsigned left;
        int unsigned m;
        int unsigned mo_i;
        t_end_date r;
        yr = 32'(y);
        mo_i = 32'(mo);
        left = 32'(d);
        left = left + 32'(n);
        for (m = 1; m < mo_i; m++)
            left += days_in_month(yr, m);
        m = 1;
        while (days_in_month(yr, m) < left) begin
            left -= days_in_month(yr, m);
            m++;
            if (m > 12) begin
                m = 1;
                yr++;
            end
        end
        r.year  = yr[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = left[DAY_W-1:0];
        return r;
    endfunction

    // results are popped before the new request is pushed at the same edge
    always @(posedge i_clk) begin : track_dates
        t_end_date want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_dates.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result %0d-%0d-%0d", res_if.end_year,
                             res_if.end_month, res_if.end_day);
            end else begin
                want = pending_dates.pop_front();
                results_seen++;
                if (want.year !== res_if.end_year || want.month !== res_if.end_month ||
                    want.day !== res_if.end_day) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                                 want.year, want.month, want.day, res_if.end_year,
                                 res_if.end_month, res_if.end_day);
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready)
            pending_dates.push_back(advance_date(req_if.start_year, req_if.start_month,
                                                 req_if.start_day, req_if.days_to_add));
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // result side pacing
    initial begin : rx_pace
        int unsigned stall;
        res_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || holding) begin
                res_if.ready <= 1'b0;
            end else if (res_if.valid && res_if.ready) begin
                stall = $urandom_range(0, rx_gap_max);
                res_if.ready <= (stall == 0);
            end else if (stall != 0) begin
                stall--;
                res_if.ready <= (stall == 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] mo,
                             input logic [DAY_W-1:0] d, input logic [ADD_W-1:0] n);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.start_year  <= y;
        req_if.start_month <= mo;
        req_if.start_day   <= d;
        req_if.days_to_add <= n;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_pacing();
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
    endtask

    task automatic test_calendar_corners();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_date(14'd2024, 4'd2, 5'd28, 14'd1);
        send_date(14'd1900, 4'd2, 5'd28, 14'd1);
        send_date(14'd2000, 4'd2, 5'd28, 14'd1);
        send_date(14'd2100, 4'd3, 5'd1, 14'd0);
        send_date(14'd2023, 4'd12, 5'd31, 14'd1);
        send_date(14'd1999, 4'd12, 5'd31, 14'd366);
        send_date(14'd0, 4'd1, 5'd1, 14'd0);
        send_date(14'd0, 4'd12, 5'd31, 14'd16383);
        send_date(14'd9999, 4'd12, 5'd31, 14'd16383);
        send_date(14'd16383, 4'd12, 5'd31, 14'd16383);
        send_date(14'd16383, 4'd1, 5'd1, 14'd16383);
        pick_pacing();
        // oversized day rolls into the next month
        send_date(14'd2023, 4'd2, 5'd31, 14'd0);
        send_date(14'd2023, 4'd4, 5'd31, 14'd0);
        // month zero
        send_date(14'd2023, 4'd0, 5'd15, 14'd10);
        send_date(14'd2024, 4'd0, 5'd31, 14'd400);
        // zero day of year gives january day zero
        send_date(14'd2023, 4'd0, 5'd0, 14'd0);
        send_date(14'd2023, 4'd1, 5'd0, 14'd0);
        // months past december count as empty
        send_date(14'd2023, 4'd13, 5'd5, 14'd0);
        send_date(14'd2023, 4'd14, 5'd31, 14'd100);
        send_date(14'd2023, 4'd15, 5'd0, 14'd0);
        send_date(14'd2024, 4'd15, 5'd0, 14'd0);
        send_date(14'd16383, 4'd15, 5'd31, 14'd16383);
        drain();
    endtask

    task automatic test_any_fields();
        for (int i = 0; i < NUM_ANY; i++) begin
            if (i % 50 == 0)
                pick_pacing();
            send_date(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(0, 15)),
                      DAY_W'($urandom_range(0, 31)), ADD_W'($urandom_range(0, 16383)));
        end
        drain();
    endtask

    task automatic test_valid_dates();
        int unsigned y;
        int unsigned mo;
        int unsigned n;
        for (int i = 0; i < NUM_VALID; i++) begin
            if (i % 50 == 0)
                pick_pacing();
            y  = $urandom_range(0, 9999);
            mo = $urandom_range(1, 12);
            n  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 16383);
            send_date(YEAR_W'(y), MONTH_W'(mo),
                      DAY_W'($urandom_range(1, days_in_month(y, mo))), ADD_W'(n));
        end
        drain();
    endtask

    task automatic test_leap_boundaries();
        int unsigned y;
        int unsigned mo;
        for (int i = 0; i < NUM_LEAP; i++) begin
            if (i % 50 == 0)
                pick_pacing();
            case ($urandom_range(0, 2))
                0: y = $urandom_range(0, 163) * 100;
                1: y = $urandom_range(0, 40) * 400;
                default: y = $urandom_range(0, 4095) * 4;
            endcase
            y  = y + $urandom_range(0, 2) - 1;
            if (y > 16383)
                y = 16383;
            mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 3);
            send_date(YEAR_W'(y), MONTH_W'(mo),
                      DAY_W'($urandom_range(1, days_in_month(y, mo))),
                      ADD_W'($urandom_range(0, 800)));
        end
        drain();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        tx_gap_max = 0;
        rx_gap_max = 0;
        fork
            begin
                holding <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding <= 1'b0;
            end
        join_none
        for (int i = 0; i < NUM_STALL; i++)
            send_date(YEAR_W'($urandom_range(0, 16383)), MONTH_W'($urandom_range(1, 12)),
                      DAY_W'($urandom_range(1, 28)), ADD_W'($urandom_range(0, 16383)));
        drain();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        holding            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.start_year  = '0;
        req_if.start_month = '0;
        req_if.start_day   = '0;
        req_if.days_to_add = '0;
        tx_gap_max         = 0;
        rx_gap_max         = 0;
        cycle_count        = 0;
        bad_results        = 0;
        results_seen       = 0;
        requests_sent      = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_calendar_corners();
        test_any_fields();
        test_valid_dates();
        test_leap_boundaries();
        test_output_stall();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        bad_results += pending_dates.size();
        $display("date requests sent %0d, end dates checked %0d, errors %0d",
                 requests_sent, results_seen, bad_results);
        $display("covered leap rules, year carry and wrap, month 0 and 13..15, day 0..31");
        if (bad_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
